// ----- rtl/core/element_lu_block_solve_macros.svh -----
// Assertion macros for the element LU block solve design.
`ifndef ELEMENT_LU_BLOCK_SOLVE_MACROS_SVH
`define ELEMENT_LU_BLOCK_SOLVE_MACROS_SVH
`ifndef SYNTH
`define ELU_ASSERT_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("element_lu_block_solve check failed");
`define ELU_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("element_lu_block_solve check failed");
`else
`define ELU_ASSERT_IMPL(label, pre, post)
`define ELU_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ----- rtl/core/elu_pkg.sv -----
// Shared types, op codes and saturating helpers for the element LU solve.
package elu_pkg;
	localparam int DOF     = 12;
	localparam int NCOEF   = 144;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 12;
	localparam int SLOT_W  = 8;
	localparam int OP_W    = 3;
	localparam int IDX_W   = 4;
	localparam int COEF_AW = 8;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [2*DATA_W-1:0] wide_t;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE     = 3'd0,
		OP_LOAD_IDX  = 3'd1,
		OP_LOAD_COEF = 3'd2,
		OP_APPLY     = 3'd3,
		OP_READ      = 3'd4
	} op_t;

	// Clamp a wide signed value into 32 bits
	function automatic data_t sat_wide(wide_t v);
		wide_t hi;
		wide_t lo;
		hi = wide_t'({1'b0, {(DATA_W-1){1'b1}}});
		lo = -hi - wide_t'(1);
		if (v > hi) begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end else if (v < lo) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end
		return v[DATA_W-1:0];
	endfunction

	// Saturating a - b
	function automatic data_t sat_sub(data_t a, data_t b);
		logic signed [DATA_W:0] d;
		d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		if (d[DATA_W] != d[DATA_W-1]) begin
			return d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end
		return d[DATA_W-1:0];
	endfunction
endpackage

// ----- rtl/core/elu_fxmul.sv -----
// Registered fixed-point multiplier with floor shift and saturation.
module elu_fxmul #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          en,
	input  elu_pkg::data_t a,
	input  elu_pkg::data_t b,
	output elu_pkg::data_t result
);
	import elu_pkg::*;

	wide_t prod_s2;

	// Register the full product
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= wide_t'(a) * wide_t'(b);
		end
	end

	// Arithmetic shift floors toward minus infinity, then clamp
	assign result = sat_wide(prod_s2 >>> FRAC_BITS);
endmodule

// ----- rtl/core/element_lu_block_solve.sv -----
// Top level of the element LU block solve: vector store, element store and sequencer.
//
// Holds a global Q16.16 vector in a registered-read RAM plus one element's 12 gather
// indices and 144 LU coefficients. A vector read is registered out of the RAM, then
// moved into the output register once no earlier result is held there under stall.
// An apply runs in order: gather, forward rows 4 to 11, backward rows with the
// inverse-diagonal scaling, scatter, and a clear of the dummy slot. Its length is set
// by the single multiply-subtract pipeline (coefficient RAM read, multiplier,
// accumulator) that every term goes through in turn, with the pipeline drained at each
// row end. The block takes one transaction at a time; a finished read result waits in
// the output register while the next transaction enters.
// No clearing pass is run after reset.
module element_lu_block_solve #(
	parameter int VECTOR_DEPTH = 4096,
	parameter int FRAC_BITS    = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [elu_pkg::OP_W-1:0]      op,
	input  logic [elu_pkg::SLOT_W-1:0]    slot,
	input  logic [elu_pkg::ADDR_W-1:0]    address,
	input  elu_pkg::data_t                value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output elu_pkg::data_t                read_value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [elu_pkg::ADDR_W-1:0]    cfg_data
);
	import elu_pkg::*;
	`include "element_lu_block_solve_macros.svh"

	localparam int AW    = $clog2(VECTOR_DEPTH);
	localparam int EXT_W = ((AW > ADDR_W) ? AW : ADDR_W) + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_RDWAIT, S_GATHER, S_ROWSTART, S_ISSUE,
		S_DRAIN, S_DIAG, S_SCATTER, S_CLEAR
	} state_t;

	state_t state_q;
	logic [ADDR_W-1:0] eq_count_q;
	logic [IDX_W-1:0]  i_q, j_q, k_q;
	logic bwd_q, diag_done_q, rd_zero_q, out_valid_q;
	data_t read_value_q;
	logic g_valid_s1, g_zero_s1;
	logic [IDX_W-1:0] g_k_s1;
	logic mac_valid_s1, mac_diag_s1, mac_valid_s2, mac_diag_s2;
	logic [IDX_W-1:0] mac_j_s1;

	data_t vec_mem [VECTOR_DEPTH];
	data_t coef_mem [NCOEF];
	logic [ADDR_W-1:0] gidx_q [DOF];
	data_t z_q [DOF];
	data_t acc_q, vec_rd_q, coef_rd_q, mul_res, mul_b, z_rd;

	logic in_fire;
	logic vec_we, vec_re, coef_re, row_done, pipe_empty;
	logic [AW-1:0] vec_wa, vec_ra;
	data_t vec_wd;
	logic [COEF_AW-1:0] coef_ra, row_base;
	logic [ADDR_W-1:0] gi;
	logic [EXT_W-1:0] in_ext, gi_ext, eq_ext;
	logic in_rng, gi_rng, eq_rng;
	logic [IDX_W-1:0] last_j, z_sel;

	assign in_stall   = (state_q != S_IDLE);
	assign in_fire    = in_valid && !in_stall;
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;

	// Range checks against the vector depth
	assign in_ext = EXT_W'(address);
	assign gi     = (k_q < IDX_W'(DOF)) ? gidx_q[k_q] : '0;
	assign gi_ext = EXT_W'(gi);
	assign eq_ext = EXT_W'(eq_count_q);
	assign in_rng = in_ext < EXT_W'(VECTOR_DEPTH);
	assign gi_rng = gi_ext < EXT_W'(VECTOR_DEPTH);
	assign eq_rng = eq_ext < EXT_W'(VECTOR_DEPTH);

	assign pipe_empty = !mac_valid_s1 && !mac_valid_s2;
	assign row_done   = (state_q == S_DRAIN) && pipe_empty && (!bwd_q || diag_done_q);
	assign last_j     = bwd_q ? IDX_W'(DOF - 1) : (i_q - IDX_W'(1));
	assign row_base   = (COEF_AW'(i_q) << 3) + (COEF_AW'(i_q) << 2);
	assign z_sel      = (state_q == S_ROWSTART) ? i_q : mac_j_s1;
	assign z_rd       = z_q[z_sel];
	assign mul_b      = mac_diag_s1 ? acc_q : z_rd;

	// Steer the vector and coefficient RAM ports
	always_comb begin
		vec_we  = 1'b0;
		vec_wa  = in_ext[AW-1:0];
		vec_wd  = value;
		vec_re  = 1'b0;
		vec_ra  = in_ext[AW-1:0];
		coef_re = 1'b0;
		coef_ra = row_base + COEF_AW'(j_q);
		case (state_q)
			S_IDLE: begin
				vec_we = in_fire && (op == OP_WRITE) && in_rng;
				vec_re = in_fire && (op == OP_READ) && in_rng;
			end
			S_GATHER: begin
				vec_re = (k_q < IDX_W'(DOF)) && gi_rng;
				vec_ra = gi_ext[AW-1:0];
			end
			S_ISSUE: begin
				coef_re = 1'b1;
			end
			S_DIAG: begin
				coef_re = 1'b1;
				coef_ra = row_base + COEF_AW'(i_q);
			end
			S_SCATTER: begin
				vec_we = gi_rng;
				vec_wa = gi_ext[AW-1:0];
				vec_wd = z_q[k_q];
			end
			S_CLEAR: begin
				vec_we = eq_rng;
				vec_wa = eq_ext[AW-1:0];
				vec_wd = '0;
			end
			default: begin
			end
		endcase
	end

	// Vector RAM
	always_ff @(posedge clk) begin
		if (vec_we) begin
			vec_mem[vec_wa] <= vec_wd;
		end
		if (vec_re) begin
			vec_rd_q <= vec_mem[vec_ra];
		end
	end

	// Coefficient RAM
	always_ff @(posedge clk) begin
		if (in_fire && (op == OP_LOAD_COEF) && (slot < SLOT_W'(NCOEF))) begin
			coef_mem[slot] <= value;
		end
		if (coef_re) begin
			coef_rd_q <= coef_mem[coef_ra];
		end
	end

	// Gather index registers
	always_ff @(posedge clk) begin
		if (in_fire && (op == OP_LOAD_IDX) && (slot < SLOT_W'(DOF))) begin
			gidx_q[slot[IDX_W-1:0]] <= address;
		end
	end

	elu_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk    (clk),
		.en     (mac_valid_s1),
		.a      (coef_rd_q),
		.b      (mul_b),
		.result (mul_res)
	);

	// Working vector and accumulator
	always_ff @(posedge clk) begin
		if (g_valid_s1) begin
			z_q[g_k_s1] <= g_zero_s1 ? '0 : vec_rd_q;
		end
		if (row_done) begin
			z_q[i_q] <= acc_q;
		end
		if (state_q == S_ROWSTART) begin
			acc_q <= z_rd;
		end else if (mac_valid_s2) begin
			acc_q <= mac_diag_s2 ? mul_res : sat_sub(acc_q, mul_res);
		end
	end

	// Sequencer, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			eq_count_q   <= '1;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			bwd_q        <= 1'b0;
			diag_done_q  <= 1'b0;
			rd_zero_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			read_value_q <= '0;
			g_valid_s1   <= 1'b0;
			g_zero_s1    <= 1'b0;
			g_k_s1       <= '0;
			mac_valid_s1 <= 1'b0;
			mac_diag_s1  <= 1'b0;
			mac_j_s1     <= '0;
			mac_valid_s2 <= 1'b0;
			mac_diag_s2  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				eq_count_q <= cfg_data;
			end
			// Drop the result once taken, unless a new one replaces it
			if (out_valid_q && !out_stall && (state_q != S_RDWAIT)) begin
				out_valid_q <= 1'b0;
			end
			g_valid_s1   <= 1'b0;
			mac_valid_s1 <= 1'b0;
			mac_diag_s1  <= 1'b0;
			mac_valid_s2 <= mac_valid_s1;
			mac_diag_s2  <= mac_diag_s1;
			case (state_q)
				S_IDLE: begin
					if (in_fire && (op == OP_READ)) begin
						rd_zero_q <= (address == eq_count_q) || !in_rng;
						state_q   <= S_RDWAIT;
					end else if (in_fire && (op == OP_APPLY)) begin
						k_q     <= '0;
						state_q <= S_GATHER;
					end
				end
				S_RDWAIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						read_value_q <= rd_zero_q ? '0 : vec_rd_q;
						state_q      <= S_IDLE;
					end
				end
				S_GATHER: begin
					// Dummy slot and out-of-range entries gather as zero
					g_valid_s1 <= (k_q < IDX_W'(DOF));
					g_k_s1     <= k_q;
					g_zero_s1  <= (gi == eq_count_q) || !gi_rng;
					k_q        <= k_q + IDX_W'(1);
					if (k_q == IDX_W'(DOF)) begin
						i_q     <= IDX_W'(4);
						bwd_q   <= 1'b0;
						state_q <= S_ROWSTART;
					end
				end
				S_ROWSTART: begin
					diag_done_q <= 1'b0;
					if (bwd_q) begin
						j_q     <= i_q + IDX_W'(1);
						state_q <= (i_q == IDX_W'(DOF - 1)) ? S_DRAIN : S_ISSUE;
					end else begin
						j_q     <= '0;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					mac_valid_s1 <= 1'b1;
					mac_j_s1     <= j_q;
					j_q          <= j_q + IDX_W'(1);
					if (j_q == last_j) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (pipe_empty) begin
						if (bwd_q && !diag_done_q) begin
							state_q <= S_DIAG;
						end else if (!bwd_q) begin
							if (i_q == IDX_W'(DOF - 1)) begin
								bwd_q <= 1'b1;
							end else begin
								i_q <= i_q + IDX_W'(1);
							end
							state_q <= S_ROWSTART;
						end else if (i_q == '0) begin
							k_q     <= '0;
							state_q <= S_SCATTER;
						end else begin
							i_q     <= i_q - IDX_W'(1);
							state_q <= S_ROWSTART;
						end
					end
				end
				S_DIAG: begin
					mac_valid_s1 <= 1'b1;
					mac_diag_s1  <= 1'b1;
					diag_done_q  <= 1'b1;
					state_q      <= S_DRAIN;
				end
				S_SCATTER: begin
					k_q <= k_q + IDX_W'(1);
					if (k_q == IDX_W'(DOF - 1)) begin
						state_q <= S_CLEAR;
					end
				end
				S_CLEAR: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ELU_ASSERT_IMPL(a_scatter_pipe_empty, state_q == S_SCATTER, !mac_valid_s1 && !mac_valid_s2)
	`ELU_ASSERT_NEXT(a_apply_gathers, in_fire && (op == OP_APPLY), state_q == S_GATHER)
	`ELU_ASSERT_NEXT(a_read_delivers, (state_q == S_RDWAIT) && !out_valid_q, out_valid_q)
	`ELU_ASSERT_IMPL(a_diag_only_bwd, mac_valid_s1 && mac_diag_s1, bwd_q)
endmodule

// ----- tb/element_lu_block_solve_checker.sv -----
// Checker for element_lu_block_solve: shadow model of the vector and element stores, read compare.
module element_lu_block_solve_checker
	import elu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [OP_W-1:0]   op,
	input  logic [SLOT_W-1:0] slot,
	input  logic [ADDR_W-1:0] address,
	input  data_t             value,
	input  logic              out_valid,
	input  logic              out_stall,
	input  data_t             read_value,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [ADDR_W-1:0] cfg_data,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 4096;
	localparam int FRAC  = 16;

	data_t             shadow_vec [DEPTH];
	logic [ADDR_W-1:0] shadow_idx [DOF];
	data_t             shadow_coef [NCOEF];
	logic [ADDR_W-1:0] shadow_eq;
	data_t             read_q [$];

	// Q16.16 product, floor shift, clamp to 32 bits
	function automatic data_t q_mul(data_t a, data_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		p = p >>> FRAC;
		if (p > 64'sh7fffffff) return 32'sh7fffffff;
		if (p < -64'sh80000000) return 32'sh80000000;
		return p[31:0];
	endfunction

	// Clamped a - b
	function automatic data_t q_sub(data_t a, data_t b);
		logic signed [32:0] d;
		d = 33'(a) - 33'(b);
		if (d > 33'sh07fffffff) return 32'sh7fffffff;
		if (d < -33'sh080000000) return 32'sh80000000;
		return d[31:0];
	endfunction

	// Gather, forward rows 4..11, scaled backward sweep, scatter
	task automatic run_element();
		data_t z [DOF];
		data_t acc;
		shadow_vec[shadow_eq] = '0;
		for (int i = 0; i < DOF; i++) z[i] = shadow_vec[shadow_idx[i]];
		for (int i = 4; i < DOF; i++) begin
			acc = z[i];
			for (int j = 0; j < i; j++) acc = q_sub(acc, q_mul(shadow_coef[i*DOF+j], z[j]));
			z[i] = acc;
		end
		for (int i = DOF - 1; i >= 0; i--) begin
			acc = z[i];
			for (int j = i + 1; j < DOF; j++)
				acc = q_sub(acc, q_mul(shadow_coef[i*DOF+j], z[j]));
			z[i] = q_mul(acc, shadow_coef[i*(DOF+1)]);
		end
		for (int i = 0; i < DOF; i++) shadow_vec[shadow_idx[i]] = z[i];
		shadow_vec[shadow_eq] = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_eq = '1;
			read_q.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			// compare a returned read against the oldest expectation
			if (out_valid && !out_stall) begin
				if (read_q.size() == 0) begin
					$error("read_value: unexpected transaction, actual %0d", read_value);
					errors <= errors + 1;
				end else begin
					if (read_value !== read_q[0]) begin
						$error("read_value: expected %0d, actual %0d", read_q[0], read_value);
						errors <= errors + 1;
					end
					void'(read_q.pop_front());
				end
			end
			if (cfg_valid && cfg_ready) shadow_eq = cfg_data;
			// advance the shadow stores on each accepted transaction
			if (in_valid && !in_stall) begin
				case (op)
					OP_WRITE:     shadow_vec[address] = value;
					OP_LOAD_IDX:  if (slot < DOF) shadow_idx[slot] = address;
					OP_LOAD_COEF: if (slot < NCOEF) shadow_coef[slot] = value;
					OP_APPLY:     run_element();
					OP_READ:      read_q.push_back(address == shadow_eq ? data_t'(0)
						: shadow_vec[address]);
					default: ;
				endcase
			end
			pending <= read_q.size();
		end
	end
endmodule

// ----- tb/element_lu_block_solve_tb.sv -----
// Testbench top for element_lu_block_solve: stimulus, flow control and verdict.
module element_lu_block_solve_tb;
	import elu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;
	localparam int APPLY_CYCLES = 320;
	localparam int HOLD_CYCLES  = 200;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              in_valid = 0;
	logic              in_stall;
	logic [OP_W-1:0]   op = '0;
	logic [SLOT_W-1:0] slot = '0;
	logic [ADDR_W-1:0] address = '0;
	data_t             value = '0;
	logic              out_valid;
	logic              out_stall = 0;
	data_t             read_value;
	logic              cfg_valid = 0;
	logic              cfg_ready;
	logic [ADDR_W-1:0] cfg_data = '0;
	int                errors;
	int                pending;

	int                idle_in = 0;
	int                idle_out = 0;
	logic              hold_req = 0;
	logic              hold_ack = 0;
	int                hold_left = 0;

	// stimulus-side bookkeeping so no never-written entry is read
	bit                vec_known [4096];
	logic [ADDR_W-1:0] known_list [$];
	logic [ADDR_W-1:0] idx_copy [DOF];
	logic [ADDR_W-1:0] eq_now = '1;

	element_lu_block_solve uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.op(op), .slot(slot), .address(address), .value(value),
		.out_valid(out_valid), .out_stall(out_stall), .read_value(read_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	element_lu_block_solve_checker chk (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.op(op), .slot(slot), .address(address), .value(value),
		.out_valid(out_valid), .out_stall(out_stall), .read_value(read_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always #5 clk = ~clk;

	// receiver: random stall, or a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
			hold_left <= 0;
			hold_ack  <= 0;
		end else if (hold_left > 0) begin
			out_stall <= 1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < idle_out);
		end
	end

	initial begin
		#5ms;
		$display("element_lu_block_solve_tb: FAIL");
		$finish;
	end

	// offer one transaction and hold it until accepted
	task automatic send(logic [OP_W-1:0] o, logic [SLOT_W-1:0] s,
			logic [ADDR_W-1:0] a, data_t v);
		while ($urandom_range(0, 99) < idle_in) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		op       <= o;
		slot     <= s;
		address  <= a;
		value    <= v;
		do @(posedge clk); while (in_stall);
		if (o == OP_WRITE && !vec_known[a]) begin
			vec_known[a] = 1;
			known_list.push_back(a);
		end
		if (o == OP_LOAD_IDX && s < DOF) idx_copy[s] = a;
	endtask

	// drain reads, let an apply finish, then write eq_count
	task automatic set_eq(logic [ADDR_W-1:0] v);
		in_valid <= 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (APPLY_CYCLES) @(posedge clk);
		cfg_valid <= 1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		eq_now = v;
	endtask

	function automatic logic [ADDR_W-1:0] pick_known();
		if ($urandom_range(0, 9) == 0) return eq_now;
		return known_list[$urandom_range(0, known_list.size() - 1)];
	endfunction

	function automatic data_t small_val();
		return data_t'($signed($urandom_range(0, 196608)) - 98304);
	endfunction

	// repoint any slot whose target was never written, then apply
	task automatic apply_safe();
		for (int i = 0; i < DOF; i++)
			if (!vec_known[idx_copy[i]] && idx_copy[i] != eq_now)
				send(OP_LOAD_IDX, SLOT_W'(i), pick_known(), data_t'($urandom));
		send(OP_APPLY, '0, ADDR_W'($urandom), data_t'($urandom));
		for (int i = 0; i < DOF; i++) begin
			if (!vec_known[idx_copy[i]]) begin
				vec_known[idx_copy[i]] = 1;
				known_list.push_back(idx_copy[i]);
			end
		end
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			send(OP_WRITE, SLOT_W'($urandom),
				$urandom_range(0, 1) ? ADDR_W'($urandom_range(0, 31)) : ADDR_W'($urandom),
				$urandom_range(0, 2) ? small_val() : data_t'($urandom));
		end else if (r < 55) begin
			send(OP_READ, SLOT_W'($urandom), pick_known(), data_t'($urandom));
		end else if (r < 67) begin
			send(OP_LOAD_IDX, SLOT_W'($urandom_range(0, DOF - 1)), pick_known(),
				data_t'($urandom));
		end else if (r < 87) begin
			send(OP_LOAD_COEF, SLOT_W'($urandom_range(0, NCOEF - 1)), ADDR_W'($urandom),
				$urandom_range(0, 4) ? small_val() : data_t'($urandom));
		end else if (r < 93) begin
			apply_safe();
		end else if (r < 96) begin
			send(OP_LOAD_IDX, SLOT_W'($urandom_range(DOF, 255)), ADDR_W'($urandom),
				data_t'($urandom));
		end else if (r < 98) begin
			send(OP_LOAD_COEF, SLOT_W'($urandom_range(NCOEF, 255)), ADDR_W'($urandom),
				data_t'($urandom));
		end else begin
			send(OP_SPARE_A + OP_W'($urandom_range(0, 2)), SLOT_W'($urandom),
				ADDR_W'($urandom), data_t'($urandom));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: sender idles lightly, receiver heavily
		idle_in  = 14;
		idle_out = 56;
		set_eq('1);
		send(OP_WRITE, '0, '0, 32'sh7fffffff);
		send(OP_WRITE, '1, 12'd1, 32'sh80000000);
		send(OP_WRITE, '0, 12'd2048, 32'sh00010000);
		send(OP_WRITE, '0, 12'd3, -32'sh00018000);
		send(OP_WRITE, '0, '1, 32'sh12345678);
		send(OP_READ, '0, '1, '0);
		send(OP_READ, '0, 12'd1, '0);
		for (int i = 0; i < DOF; i++)
			send(OP_LOAD_IDX, SLOT_W'(i), (i == 11) ? 12'd2048 : (i == 7) ? 12'hfff
				: ADDR_W'(i % 4 == 0 ? 0 : i % 4 == 1 ? 1 : i % 4 == 2 ? 2048 : 3), '0);
		for (int i = 0; i < NCOEF; i++)
			send(OP_LOAD_COEF, SLOT_W'(i), '0, (i % 13 == 0) ? 32'sh00010000
				: (i == 100) ? 32'sh7fffffff : (i == 30) ? 32'sh80000000 : small_val());
		send(OP_LOAD_IDX, 8'd12, 12'd5, '0);
		send(OP_LOAD_COEF, 8'd200, '0, 32'sh7fffffff);
		send(OP_SPARE_A, '0, '0, '0);
		send(OP_SPARE_B, '0, '0, '0);
		send(OP_SPARE_C, '1, '1, '1);
		apply_safe();
		send(OP_READ, '0, '0, '0);
		send(OP_READ, '0, 12'd2048, '0);
		send(OP_READ, '0, 12'd3, '0);

		// random, three idling regimes and three eq_count settings
		for (int i = 0; i < 160; i++) random_item();
		idle_in  = 56;
		idle_out = 14;
		set_eq('0);
		for (int i = 0; i < 160; i++) random_item();
		idle_in  = 0;
		idle_out = 0;
		set_eq(ADDR_W'($urandom));
		// receiver holds off while reads keep coming
		hold_req <= ~hold_req;
		for (int i = 0; i < 12; i++) send(OP_READ, '0, pick_known(), '0);
		in_valid <= 0;
		@(posedge clk);
		wait (pending == 0);
		for (int i = 0; i < 150; i++) random_item();
		in_valid <= 0;

		@(posedge clk);
		wait (pending == 0);
		repeat (APPLY_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("element_lu_block_solve_tb: PASS");
		end else begin
			$display("element_lu_block_solve_tb: FAIL");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/elu_pkg.sv
rtl/core/elu_fxmul.sv
rtl/core/element_lu_block_solve.sv
tb/element_lu_block_solve_checker.sv
tb/element_lu_block_solve_tb.sv
